// ===== rtl/core/hat_pkg.sv =====
// Shared types and constants for the heartbeat age table.
// Used by hat_store and heartbeat_age_table; depends on nothing else.
package hat_pkg;

	localparam int ID_W        = 63;
	localparam int TIME_W      = 48;
	localparam int AGE_W       = 49;
	localparam int ENTRIES_DEF = 8;

	localparam logic KIND_TOUCH = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Age returned for a zero or unknown identifier.
	localparam logic signed [AGE_W-1:0] AGE_NONE = '1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// One table entry as it sits in the store.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
	} entry_t;

endpackage

// ===== rtl/core/hat_store.sv =====
// Entry store of the heartbeat age table: one write port, one registered read port.
// Depends on hat_pkg for the entry type.
module hat_store #(
	parameter int ENTRIES = hat_pkg::ENTRIES_DEF,
	parameter int IDX_W   = 3
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  hat_pkg::entry_t      wr_data,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	output hat_pkg::entry_t      rd_data
);

	hat_pkg::entry_t mem_q [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/heartbeat_age_table.sv =====
// Top level of the heartbeat age table: sequencer, shared compare unit and result register.
// Depends on hat_pkg and hat_store.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+----------------------------
//   req     | in        | req_valid / req_stall | kind, source_id, time_now
//   rsp     | out       | rsp_valid / rsp_stall | age_ms
//
// One item is handled at a time. An item with a zero identifier, or one that
// arrives while the table is empty, goes straight to the result step; otherwise
// the entries are read one per cycle through the single read port of the entry
// store and checked by one shared comparator, until a match or the last entry.
// Reset clears the state machine, the entry count and the result valid flag; the
// entries themselves are not cleared, since only entries below the count are read.
// A stall on rsp holds only the last step of a query, and only while an earlier
// beat still waits in the result register; touches never wait on rsp.
module heartbeat_age_table #(
	parameter int ENTRIES = hat_pkg::ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic                                 kind,
	input  logic [hat_pkg::ID_W-1:0]             source_id,
	input  logic [hat_pkg::TIME_W-1:0]           time_now,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic signed [hat_pkg::AGE_W-1:0]     age_ms
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	hat_pkg::state_t state_q, state_d;

	// Item held while it is worked on.
	logic                        kind_q;
	logic [hat_pkg::ID_W-1:0]    id_q;
	logic [hat_pkg::TIME_W-1:0]  now_q;

	logic [CNT_W-1:0]            used_q;
	logic [CNT_W-1:0]            addr_cnt_q;
	logic [CNT_W-1:0]            cmp_idx_q;
	logic                        cmp_vld_q;

	logic                        found_q;
	logic [IDX_W-1:0]            match_idx_q;
	logic [hat_pkg::TIME_W-1:0]  match_time_q;
	logic [IDX_W-1:0]            best_idx_q;
	logic [hat_pkg::TIME_W-1:0]  best_time_q;

	logic                        rsp_valid_q;
	logic signed [hat_pkg::AGE_W-1:0] age_q;

	logic                        req_accept;
	logic                        issue_more;
	logic                        scan_hit;
	logic                        scan_last;
	logic                        rd_en;
	logic                        wr_en;
	logic                        rsp_load;
	logic [IDX_W-1:0]            wr_addr;
	hat_pkg::entry_t             wr_data;
	hat_pkg::entry_t             rd_data;
	logic signed [hat_pkg::AGE_W-1:0] age_d;

	hat_store #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr_cnt_q[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	assign req_stall  = (state_q != hat_pkg::ST_IDLE);
	assign req_accept = req_valid && !req_stall;
	assign issue_more = (addr_cnt_q < used_q);

	// The shared compare unit: identifier match on the entry just read.
	assign scan_hit  = cmp_vld_q && (rd_data.id == id_q);
	assign scan_last = cmp_vld_q && ((cmp_idx_q + CNT_W'(1)) == used_q);

	// A refresh rewrites the matching entry, a new identifier takes the next
	// free entry, and once the table is full it replaces the oldest one.
	always_comb begin
		if (found_q) begin
			wr_addr = match_idx_q;
		end else if (used_q < CNT_W'(ENTRIES)) begin
			wr_addr = used_q[IDX_W-1:0];
		end else begin
			wr_addr = best_idx_q;
		end
	end

	assign wr_data = '{id: id_q, stamp: now_q};

	// Age of a found entry; a clock that has gone backwards gives zero.
	always_comb begin
		if (!found_q || (id_q == '0)) begin
			age_d = hat_pkg::AGE_NONE;
		end else if (now_q >= match_time_q) begin
			age_d = {1'b0, now_q - match_time_q};
		end else begin
			age_d = '0;
		end
	end

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		rsp_load = 1'b0;
		case (state_q)
			hat_pkg::ST_IDLE: begin
				if (req_valid) begin
					if ((source_id == '0) || (used_q == '0)) begin
						state_d = hat_pkg::ST_DONE;
					end else begin
						state_d = hat_pkg::ST_SCAN;
					end
				end
			end
			hat_pkg::ST_SCAN: begin
				rd_en = issue_more;
				if (scan_hit || scan_last) begin
					state_d = hat_pkg::ST_DONE;
				end
			end
			hat_pkg::ST_DONE: begin
				if (kind_q == hat_pkg::KIND_TOUCH) begin
					wr_en   = (id_q != '0);
					state_d = hat_pkg::ST_IDLE;
				end else if (!(rsp_valid_q && rsp_stall)) begin
					rsp_load = 1'b1;
					state_d  = hat_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hat_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hat_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			addr_cnt_q  <= '0;
			cmp_idx_q   <= '0;
			cmp_vld_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_accept) begin
				addr_cnt_q <= '0;
				cmp_vld_q  <= 1'b0;
			end else if (rd_en) begin
				addr_cnt_q <= addr_cnt_q + CNT_W'(1);
				cmp_idx_q  <= addr_cnt_q;
				cmp_vld_q  <= 1'b1;
			end else begin
				cmp_vld_q  <= 1'b0;
			end
			if (wr_en && !found_q && (used_q < CNT_W'(ENTRIES))) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			kind_q     <= kind;
			id_q       <= source_id;
			now_q      <= time_now;
			found_q    <= 1'b0;
			best_idx_q <= '0;
		end else if (state_q == hat_pkg::ST_SCAN) begin
			if (scan_hit) begin
				found_q      <= 1'b1;
				match_idx_q  <= cmp_idx_q[IDX_W-1:0];
				match_time_q <= rd_data.stamp;
			end else if (cmp_vld_q &&
			             ((cmp_idx_q == '0) || (rd_data.stamp < best_time_q))) begin
				// Strictly older only, so the lowest index wins among equal times.
				best_idx_q  <= cmp_idx_q[IDX_W-1:0];
				best_time_q <= rd_data.stamp;
			end
		end
		if (rsp_load) begin
			age_q <= age_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign age_ms    = age_q;

`ifndef SYNTH
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond table size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q != hat_pkg::ST_IDLE)
		else $error("accepted beat did not start work");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q == $past(used_q)) || (used_q == $past(used_q) + CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_q |-> cmp_idx_q < used_q)
		else $error("scan read an entry beyond the count");
`endif

endmodule
